// ----- rtl/plq_pkg.sv -----
// plq_pkg: shared types and codes for the price level order queue
`default_nettype none
package plq_pkg;

   localparam int TOTAL_W   = 40;
   localparam int COUNT_W   = 9;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 40;

   typedef logic [2:0] op_code_type;
   localparam op_code_type OP_ADD    = 3'd0;
   localparam op_code_type OP_CANCEL = 3'd1;
   localparam op_code_type OP_MODIFY = 3'd2;
   localparam op_code_type OP_FILL   = 3'd3;
   localparam op_code_type OP_REMOVE = 3'd4;
   localparam op_code_type OP_QUERY  = 3'd5;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_DUP      = 3'd1;
   localparam status_type ST_NOTFOUND = 3'd2;
   localparam status_type ST_PRICE    = 3'd3;
   localparam status_type ST_FULL     = 3'd4;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_LEVEL_PRICE   = 1'd0;
   localparam csr_idx_type CSR_INITIAL_TOTAL = 1'd1;

   typedef struct packed {
      op_code_type  operation;
      logic [31:0]  order_id;
      logic [31:0]  new_order_id;
      logic [31:0]  price;
      logic [31:0]  quantity;
      logic [63:0]  activation_time;
      logic [63:0]  deactivation_time;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [TOTAL_W-1:0] total_quantity;
      logic [COUNT_W-1:0] order_count;
      logic [31:0]        head_order_id;
      logic [63:0]        found_activation;
      logic [63:0]        found_deactivation;
   } rsp_type;

   typedef struct packed {
      logic        do_scan;
      logic        do_cancel;
      logic        sub_qty;
      logic        do_add;
      logic        is_modify;
      logic        is_fill;
      logic        is_query;
      logic        price_ok;
      logic [31:0] key_id;
      logic [31:0] add_id;
      logic [31:0] quantity;
      logic [63:0] act_time;
      logic [63:0] deact_time;
   } cmd_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] qty;
      logic [63:0] act_time;
      logic [63:0] deact_time;
   } rec_type;

endpackage
`default_nettype wire

// ----- rtl/plq_front.sv -----
// plq_front: takes request transfers, decodes them and queues commands
`default_nettype none
module plq_front
   import plq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   input  wire logic        csr_we,
   input  wire csr_idx_type csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output logic             cmd_valid,
   output cmd_type          cmd,
   input  wire logic        cmd_take
);

   cmd_type     fifo_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] level_price_ff;
   cmd_type     dec;
   logic        do_push, do_pop;
   op_code_type op;

   always_comb begin
      op            = req_data.operation;
      dec.do_add    = (op == OP_ADD) || (op == OP_MODIFY);
      dec.do_cancel = (op == OP_CANCEL) || (op == OP_MODIFY) || (op == OP_REMOVE);
      dec.sub_qty   = (op == OP_CANCEL) || (op == OP_MODIFY);
      dec.is_modify = (op == OP_MODIFY);
      dec.is_fill   = (op == OP_FILL);
      dec.is_query  = (op == OP_QUERY);
      dec.do_scan   = dec.do_add || dec.do_cancel || dec.is_query;
      dec.price_ok  = (req_data.price == level_price_ff);
      dec.key_id    = req_data.order_id;
      dec.add_id    = (op == OP_MODIFY) ? req_data.new_order_id : req_data.order_id;
      dec.quantity  = req_data.quantity;
      dec.act_time  = req_data.activation_time;
      dec.deact_time = req_data.deactivation_time;
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = fifo_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
         cnt_ff         <= 2'd0;
         level_price_ff <= 32'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         if (csr_we && csr_index == CSR_LEVEL_PRICE) begin
            level_price_ff <= csr_wdata[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         fifo_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/plq_exec.sv -----
// plq_exec: slot search, linked list update, totals and the result register
`default_nettype none
module plq_exec
   import plq_pkg::*;
#(
   parameter int MAX_ORDERS = 256
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   input  wire cmd_type     cmd,
   output logic             cmd_take,
   input  wire logic        csr_we,
   input  wire csr_idx_type csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data
);

   localparam int AW = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
   localparam int CW = $clog2(MAX_ORDERS + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ORDERS);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_SCAN     = 9'b000000010,
      S_DECIDE   = 9'b000000100,
      S_UNL_RD   = 9'b000001000,
      S_UNL_WR   = 9'b000010000,
      S_ADD_LINK = 9'b000100000,
      S_ADD_REC  = 9'b001000000,
      S_HEAD_RD  = 9'b010000000,
      S_HEAD_CAP = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   rec_type        rec_mem  [MAX_ORDERS];
   logic [AW-1:0]  next_mem [MAX_ORDERS];
   logic [AW-1:0]  prev_mem [MAX_ORDERS];
   rec_type        rec_rd_ff;
   logic [AW-1:0]  next_rd_ff, prev_rd_ff;
   logic [AW-1:0]  rec_addr;

   logic [MAX_ORDERS-1:0] valid_ff;
   logic [CW-1:0]  cnt_ff;
   logic           chk_ff;
   logic [AW-1:0]  chk_idx_ff;
   logic [AW-1:0]  head_ff, tail_ff;
   logic [CW-1:0]  count_ff;
   logic [TOTAL_W-1:0] total_ff;
   cmd_type        cmd_ff;

   logic           hit_key_ff, hit_add_ff, free_found_ff;
   logic [AW-1:0]  key_slot_ff, free_slot_ff;
   logic [31:0]    key_qty_ff;
   logic [63:0]    key_act_ff, key_deact_ff;
   status_type     status_ff;
   logic           add_go_ff;
   logic [AW-1:0]  add_slot_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff;

   logic           issuing, slot_v;
   logic           dup, have_free, use_key_slot;
   status_type     add_st, cancel_st, status_in;
   logic [CW-1:0]  count_dec;
   logic [TOTAL_W:0] add_sum;
   logic           rsp_load;

   logic           next_we, prev_we, rec_we;
   logic [AW-1:0]  next_wa, prev_wa, next_wd, prev_wd;

   assign issuing  = (cnt_ff != CNT_MAX);
   assign slot_v   = valid_ff[chk_idx_ff];
   assign cmd_take = (state_ff == S_IDLE) && cmd_valid;
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign rec_addr = (state_ff == S_SCAN) ? cnt_ff[AW-1:0] : head_ff;
   assign count_dec = count_ff - CW'(1);
   assign add_sum  = {1'b0, total_ff} + (TOTAL_W + 1)'(cmd_ff.quantity);
   assign rsp_load = (state_ff == S_HEAD_CAP) && (!rsp_valid_ff || pop);

   always_comb begin
      dup = hit_add_ff && !(cmd_ff.do_cancel && hit_key_ff && cmd_ff.add_id == cmd_ff.key_id);
      use_key_slot = cmd_ff.do_cancel && hit_key_ff
                     && (!free_found_ff || key_slot_ff < free_slot_ff);
      have_free = free_found_ff || (cmd_ff.do_cancel && hit_key_ff);
      priority if (!cmd_ff.price_ok) add_st = ST_PRICE;
      else if (dup)                  add_st = ST_DUP;
      else if (!have_free)           add_st = ST_FULL;
      else                           add_st = ST_OK;
      cancel_st = hit_key_ff ? ST_OK : ST_NOTFOUND;
      priority if (cmd_ff.is_modify)
         status_in = (add_st != ST_OK) ? add_st : cancel_st;
      else if (cmd_ff.do_add)
         status_in = add_st;
      else if (cmd_ff.do_cancel || cmd_ff.is_query)
         status_in = cancel_st;
      else
         status_in = ST_OK;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (cmd_valid) state_in = cmd.do_scan ? S_SCAN : S_DECIDE;
         S_SCAN:     if (!issuing && !chk_ff) state_in = S_DECIDE;
         S_DECIDE: begin
            if (cmd_ff.do_cancel && hit_key_ff) state_in = S_UNL_RD;
            else if (cmd_ff.do_add && add_st == ST_OK) state_in = S_ADD_LINK;
            else state_in = S_HEAD_RD;
         end
         S_UNL_RD:   state_in = S_UNL_WR;
         S_UNL_WR:   state_in = add_go_ff ? S_ADD_LINK : S_HEAD_RD;
         S_ADD_LINK: state_in = S_ADD_REC;
         S_ADD_REC:  state_in = S_HEAD_RD;
         S_HEAD_RD:  state_in = S_HEAD_CAP;
         S_HEAD_CAP: if (rsp_load) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      next_we = 1'b0;
      next_wa = next_rd_ff;
      next_wd = '0;
      prev_we = 1'b0;
      prev_wa = next_rd_ff;
      prev_wd = prev_rd_ff;
      rec_we  = (state_ff == S_ADD_REC);
      if (state_ff == S_UNL_WR) begin
         next_we = (key_slot_ff != head_ff);
         next_wa = prev_rd_ff;
         next_wd = next_rd_ff;
         prev_we = (key_slot_ff != tail_ff);
      end else if (state_ff == S_ADD_LINK) begin
         next_we = (count_ff != '0);
         next_wa = tail_ff;
         next_wd = add_slot_ff;
      end else if (state_ff == S_ADD_REC) begin
         next_we = 1'b1;
         next_wa = add_slot_ff;
         prev_we = 1'b1;
         prev_wa = add_slot_ff;
         prev_wd = (count_ff == '0) ? '0 : tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      rec_rd_ff  <= rec_mem[rec_addr];
      next_rd_ff <= next_mem[key_slot_ff];
      prev_rd_ff <= prev_mem[key_slot_ff];
      if (rec_we) begin
         rec_mem[add_slot_ff] <= '{id: cmd_ff.add_id, qty: cmd_ff.quantity,
                                   act_time: cmd_ff.act_time,
                                   deact_time: cmd_ff.deact_time};
      end
      if (next_we) next_mem[next_wa] <= next_wd;
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         chk_ff       <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_SCAN) begin
            chk_ff <= issuing;
            if (issuing) cnt_ff <= cnt_ff + CW'(1);
         end else begin
            chk_ff <= 1'b0;
            cnt_ff <= '0;
         end
         if (state_ff == S_DECIDE && cmd_ff.is_fill) begin
            total_ff <= (TOTAL_W'(cmd_ff.quantity) >= total_ff) ? '0
                        : total_ff - TOTAL_W'(cmd_ff.quantity);
         end
         if (state_ff == S_UNL_WR) begin
            valid_ff[key_slot_ff] <= 1'b0;
            count_ff <= count_dec;
            if (count_dec == '0) begin
               head_ff <= '0;
               tail_ff <= '0;
            end else begin
               if (key_slot_ff == head_ff) head_ff <= next_rd_ff;
               if (key_slot_ff == tail_ff) tail_ff <= prev_rd_ff;
            end
            if (cmd_ff.sub_qty) begin
               total_ff <= (TOTAL_W'(key_qty_ff) >= total_ff) ? '0
                           : total_ff - TOTAL_W'(key_qty_ff);
            end
         end
         if (state_ff == S_ADD_REC) begin
            valid_ff[add_slot_ff] <= 1'b1;
            count_ff <= count_ff + CW'(1);
            tail_ff  <= add_slot_ff;
            if (count_ff == '0) head_ff <= add_slot_ff;
            total_ff <= add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];
         end
         if (csr_we && csr_index == CSR_INITIAL_TOTAL) begin
            total_ff <= csr_wdata[TOTAL_W-1:0];
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (pop) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && cmd_valid) begin
         cmd_ff        <= cmd;
         hit_key_ff    <= 1'b0;
         hit_add_ff    <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (state_ff == S_SCAN) begin
         chk_idx_ff <= cnt_ff[AW-1:0];
         if (chk_ff) begin
            if (slot_v && rec_rd_ff.id == cmd_ff.key_id && !hit_key_ff) begin
               hit_key_ff   <= 1'b1;
               key_slot_ff  <= chk_idx_ff;
               key_qty_ff   <= rec_rd_ff.qty;
               key_act_ff   <= rec_rd_ff.act_time;
               key_deact_ff <= rec_rd_ff.deact_time;
            end
            if (slot_v && rec_rd_ff.id == cmd_ff.add_id) hit_add_ff <= 1'b1;
            if (!slot_v && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_slot_ff  <= chk_idx_ff;
            end
         end
      end
      if (state_ff == S_DECIDE) begin
         status_ff   <= status_in;
         add_go_ff   <= cmd_ff.do_add && (add_st == ST_OK);
         add_slot_ff <= use_key_slot ? key_slot_ff : free_slot_ff;
      end
      if (rsp_load) begin
         rsp_ff.status         <= status_ff;
         rsp_ff.total_quantity <= total_ff;
         rsp_ff.order_count    <= COUNT_W'(count_ff);
         rsp_ff.head_order_id  <= (count_ff != '0) ? rec_rd_ff.id : 32'd0;
         rsp_ff.found_activation   <= (cmd_ff.is_query && hit_key_ff) ? key_act_ff : 64'd0;
         rsp_ff.found_deactivation <= (cmd_ff.is_query && hit_key_ff) ? key_deact_ff : 64'd0;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/price_level_order_queue.sv -----
// price_level_order_queue: top level of one order book price level
//
//   channel   | ports                          | transfer
//   request   | push, full, req_data           | push && !full
//   result    | empty, pop, rsp_data           | pop && !empty
//   registers | csr_we, csr_index, csr_wdata   | csr_we
//
// a linear id search reads one slot record a cycle from the slot memory,
// then the list updates and the head id read follow in their own states;
// fill skips the search and only updates the total before the head id read
// reset is synchronous and needs no clearing pass; valid bits are flip-flops
// a two entry command queue keeps taking requests while a result waits
`default_nettype none
module price_level_order_queue
   import plq_pkg::*;
#(
   parameter int MAX_ORDERS = 256
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire req_type     req_data,
   output logic             empty,
   input  wire logic        pop,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire csr_idx_type csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   logic    cmd_valid, cmd_take;
   cmd_type cmd;

   plq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   plq_exec #(.MAX_ORDERS(MAX_ORDERS)) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ----- rtl/plq_checker.sv -----
// plq_checker: port level checks for the price level order queue
`default_nettype none
module plq_checker
   import plq_pkg::*;
#(
   parameter int MAX_ORDERS = 256
)
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    empty,
   input wire logic    pop,
   input wire rsp_type rsp_data
);

   localparam bit WIDE_COUNT = (MAX_ORDERS > 511);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result dropped without transfer");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_data))
      else $error("result changed while waiting");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (WIDE_COUNT || rsp_data.order_count <= COUNT_W'(MAX_ORDERS)))
      else $error("order count beyond capacity");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.order_count == '0) |-> rsp_data.head_order_id == 32'd0)
      else $error("head id nonzero on empty level");

endmodule

bind price_level_order_queue plq_checker #(.MAX_ORDERS(MAX_ORDERS)) u_plq_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
`default_nettype wire
